// ===== rtl/bpled_pkg.sv =====
// shared types and constants for the burst peak loud event detector
package bpled_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int PEAK_W = SAMPLE_BITS - 1;
    localparam int THRESH_W = 15;
    localparam int HOLDOFF_W = 16;
    localparam int TIMER_BITS_DEFAULT = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_TAKE = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_PEAK_THRESHOLD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF_TICKS = 1'd1;

    localparam logic [THRESH_W-1:0] PEAK_THRESHOLD_RESET = 15'd2000;
    localparam logic [HOLDOFF_W-1:0] HOLDOFF_TICKS_RESET = 16'd100;

    typedef struct packed {
        logic [1:0] cmd;
        logic signed [SAMPLE_BITS-1:0] sample_value;
        logic last_in_burst;
    } t_in_beat;

    typedef struct packed {
        logic loud_event;
        logic [PEAK_W-1:0] burst_peak;
        logic armed;
        logic flag_taken;
    } t_out_beat;

endpackage

// ===== rtl/bpled_core.sv =====
// detector state: running peak, holdoff timer and loud flag
module bpled_core
    import bpled_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  t_in_beat             i_beat,
    input  logic [THRESH_W-1:0]  i_peak_threshold,
    input  logic [HOLDOFF_W-1:0] i_holdoff_ticks,
    output t_out_beat            o_result
);

    localparam int CMP_W = (TIMER_BITS > HOLDOFF_W) ? TIMER_BITS : HOLDOFF_W;

    logic [PEAK_W-1:0]     r_running_peak, n_running_peak;
    logic                  r_holding_off, n_holding_off;
    logic [TIMER_BITS-1:0] r_holdoff_elapsed, n_holdoff_elapsed;
    logic                  r_loud_latched, n_loud_latched;

    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] neg;
    logic [PEAK_W-1:0]      mag;
    logic [PEAK_W-1:0]      peak_max;
    logic [TIMER_BITS-1:0]  elapsed_inc;

    // magnitude, most negative code saturates
    always_comb begin
        raw = i_beat.sample_value;
        neg = ~raw + SAMPLE_BITS'(1);
        if (raw[SAMPLE_BITS-1]) begin
            mag = neg[SAMPLE_BITS-1] ? {PEAK_W{1'b1}} : neg[PEAK_W-1:0];
        end else begin
            mag = raw[PEAK_W-1:0];
        end
        peak_max = (mag > r_running_peak) ? mag : r_running_peak;
        elapsed_inc = (r_holdoff_elapsed == {TIMER_BITS{1'b1}}) ?
                      r_holdoff_elapsed : r_holdoff_elapsed + TIMER_BITS'(1);
    end

    always_comb begin
        n_running_peak = r_running_peak;
        n_holding_off = r_holding_off;
        n_holdoff_elapsed = r_holdoff_elapsed;
        n_loud_latched = r_loud_latched;
        o_result = '0;
        case (i_beat.cmd)
            CMD_SAMPLE: begin
                if (!r_holding_off) begin
                    n_running_peak = peak_max;
                    if (i_beat.last_in_burst) begin
                        o_result.burst_peak = peak_max;
                        n_running_peak = '0;
                        if (peak_max >= i_peak_threshold) begin
                            o_result.loud_event = 1'b1;
                            n_loud_latched = 1'b1;
                            n_holding_off = 1'b1;
                            n_holdoff_elapsed = '0;
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (r_holding_off) begin
                    n_holdoff_elapsed = elapsed_inc;
                    if (CMP_W'(elapsed_inc) >= CMP_W'(i_holdoff_ticks)) begin
                        n_holding_off = 1'b0;
                    end
                end
            end
            CMD_TAKE: begin
                o_result.flag_taken = r_loud_latched;
                n_loud_latched = 1'b0;
            end
            default: begin
            end
        endcase
        o_result.armed = !n_holding_off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_peak <= '0;
            r_holding_off <= 1'b1;
            r_holdoff_elapsed <= '0;
            r_loud_latched <= 1'b0;
        end else if (i_accept) begin
            r_running_peak <= n_running_peak;
            r_holding_off <= n_holding_off;
            r_holdoff_elapsed <= n_holdoff_elapsed;
            r_loud_latched <= n_loud_latched;
        end
    end

endmodule

// ===== rtl/burst_peak_loud_event_detector.sv =====
// top level of the burst peak loud event detector
// The block takes one beat per clock while o_in_stall is low and gives
// exactly one result beat per input beat; the peak update, threshold compare
// and holdoff timer are combinational and registered when a beat is accepted.
// The result sits in an output register backed by one skid register, so input
// beats keep flowing while a result waits; o_in_stall rises only when both
// hold results. After reset the detector is in holdoff and drops samples until
// holdoff_ticks ticks have passed. Write configuration only while idle.
module burst_peak_loud_event_detector
    import bpled_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_beat               i_in_beat,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_beat              o_out_beat,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [THRESH_W-1:0]  r_peak_threshold;
    logic [HOLDOFF_W-1:0] r_holdoff_ticks;

    logic      r_out_valid;
    t_out_beat r_out_beat;
    logic      r_skid_valid;
    t_out_beat r_skid_beat;

    logic      accept;
    logic      take_out;
    t_out_beat result;

    assign o_in_stall = r_skid_valid;
    assign accept = i_in_valid && !r_skid_valid;
    assign take_out = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_beat = r_out_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_threshold <= PEAK_THRESHOLD_RESET;
            r_holdoff_ticks <= HOLDOFF_TICKS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PEAK_THRESHOLD: r_peak_threshold <= i_cfg_data[THRESH_W-1:0];
                REG_HOLDOFF_TICKS: r_holdoff_ticks <= i_cfg_data[HOLDOFF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bpled_core #(
        .TIMER_BITS(TIMER_BITS)
    ) u_core (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_accept(accept),
        .i_beat(i_in_beat),
        .i_peak_threshold(r_peak_threshold),
        .i_holdoff_ticks(r_holdoff_ticks),
        .o_result(result)
    );

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (!r_out_valid || take_out) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (take_out) begin
                r_out_valid <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!r_out_valid || take_out) begin
                r_out_beat <= result;
            end else begin
                r_skid_beat <= result;
            end
        end else if (take_out && r_skid_valid) begin
            r_out_beat <= r_skid_beat;
        end
    end

endmodule

// ===== verif/burst_peak_loud_event_detector_test.sv =====
// self-checking testbench for the burst peak loud event detector
`timescale 1ns / 100ps

module burst_peak_loud_event_detector_test;
    import bpled_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic o_in_stall;
    t_in_beat in_beat = '0;
    logic o_out_valid;
    logic out_stall = 1'b0;
    t_out_beat o_out_beat;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // detector state as the predictor sees it
    logic [PEAK_W-1:0] run_peak = '0;
    logic in_holdoff = 1'b1;
    logic [TIMER_BITS_DEFAULT-1:0] ticks_elapsed = '0;
    logic loud_flag = 1'b0;
    logic [THRESH_W-1:0] thr_cfg = PEAK_THRESHOLD_RESET;
    logic [HOLDOFF_W-1:0] hold_cfg = HOLDOFF_TICKS_RESET;

    t_out_beat expected_results[$];
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold_cycles = 0;
    int cycle_count = 0;
    int beats_sent = 0;
    int live_beats = 0;
    int results_checked = 0;
    int mismatches = 0;
    int loud_events = 0;
    int flags_taken = 0;
    int reg_writes = 0;

    burst_peak_loud_event_detector i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_results.size());
            $display("burst_peak_loud_event_detector_test: FAIL");
            $finish;
        end
    end

    function automatic t_out_beat predict_result(input t_in_beat b);
        t_out_beat r;
        logic signed [SAMPLE_BITS:0] wide;
        logic [PEAK_W-1:0] mag;
        r = '0;
        case (b.cmd)
            CMD_SAMPLE: begin
                if (!in_holdoff) begin
                    wide = (SAMPLE_BITS+1)'(b.sample_value);
                    if (wide < 0) wide = -wide;
                    mag = wide[SAMPLE_BITS-1] ? '1 : wide[PEAK_W-1:0];
                    if (mag > run_peak) run_peak = mag;
                    if (b.last_in_burst) begin
                        r.burst_peak = run_peak;
                        if (run_peak >= thr_cfg) begin
                            r.loud_event = 1'b1;
                            loud_flag = 1'b1;
                            in_holdoff = 1'b1;
                            ticks_elapsed = '0;
                            loud_events++;
                        end
                        run_peak = '0;
                    end
                end
            end
            CMD_TICK: begin
                if (in_holdoff) begin
                    if (ticks_elapsed != '1) ticks_elapsed++;
                    if (ticks_elapsed >= hold_cfg) in_holdoff = 1'b0;
                end
            end
            CMD_TAKE: begin
                r.flag_taken = loud_flag;
                if (loud_flag) flags_taken++;
                loud_flag = 1'b0;
            end
            default: ;
        endcase
        r.armed = !in_holdoff;
        return r;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int v;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            v = $urandom;
        end else if (sel < 4) begin
            case ($urandom_range(0, 3))
                0: v = -32768;
                1: v = 32767;
                2: v = 0;
                default: v = -1;
            endcase
        end else begin
            v = int'(thr_cfg) + int'($urandom_range(0, 80)) - 40;
            if (v < 0) v = 0;
            if (v > 32767) v = 32767;
            if ($urandom_range(0, 1) == 1) v = -v;
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    task automatic send_beat(input logic [1:0] cmd, input logic [SAMPLE_BITS-1:0] value,
                             input logic last);
        t_in_beat b;
        int gap;
        b.cmd = cmd;
        b.sample_value = value;
        b.last_in_burst = last;
        gap = tx_idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat <= b;
        do @(posedge clk); while (o_in_stall !== 1'b0);
        if (!(cmd == CMD_SPARE || (cmd == CMD_SAMPLE && in_holdoff) ||
              (cmd == CMD_TICK && !in_holdoff)))
            live_beats++;
        beats_sent++;
        expected_results.push_back(predict_result(b));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_PEAK_THRESHOLD)
            thr_cfg = data[THRESH_W-1:0];
        else
            hold_cfg = data[HOLDOFF_W-1:0];
        reg_writes++;
    endtask

    // receiver: random stall after each beat when rx_idle_on is set, or one long hold when asked
    initial begin : result_drain
        int wait_cycles;
        wait_cycles = 0;
        forever begin
            @(posedge clk);
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                out_stall <= 1'b1;
            end else begin
                if (o_out_valid === 1'b1 && !out_stall)
                    wait_cycles = rx_idle_on ? $urandom_range(0, 9) : 0;
                else if (wait_cycles > 0)
                    wait_cycles--;
                out_stall <= (wait_cycles > 0);
            end
        end
    end

    always @(posedge clk) begin : result_check
        t_out_beat want;
        if (rst_n && o_out_valid === 1'b1 && !out_stall) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat at cycle %0d", cycle_count);
            end else begin
                want = expected_results.pop_front();
                if (o_out_beat.loud_event !== want.loud_event ||
                    o_out_beat.burst_peak !== want.burst_peak ||
                    o_out_beat.armed !== want.armed ||
                    o_out_beat.flag_taken !== want.flag_taken) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("result %0d (exp/act): loud %0b/%0b peak %0d/%0d ",
                               results_checked,
                               want.loud_event, o_out_beat.loud_event,
                               want.burst_peak, o_out_beat.burst_peak);
                        $display("armed %0b/%0b taken %0b/%0b",
                                 want.armed, o_out_beat.armed,
                                 want.flag_taken, o_out_beat.flag_taken);
                    end
                end
            end
        end
    end

    // start-up holdoff drops samples; take and spare command while held
    task automatic test_reset_holdoff();
        send_beat(CMD_SAMPLE, 16'd500, 1'b1);
        send_beat(CMD_TICK, 16'h0000, 1'b0);
        send_beat(CMD_TAKE, 16'hFFFF, 1'b1);
        send_beat(CMD_SPARE, 16'hFFFF, 1'b1);
        write_reg(REG_HOLDOFF_TICKS, 16'd0);
    endtask

    task automatic test_threshold_edges();
        send_beat(CMD_TICK, 16'h0000, 1'b0);
        send_beat(CMD_SAMPLE, 16'h8000, 1'b1);
        send_beat(CMD_TAKE, 16'h0000, 1'b0);
        send_beat(CMD_TICK, 16'h0000, 1'b0);
        send_beat(CMD_SAMPLE, 16'd100, 1'b0);
        send_beat(CMD_SAMPLE, -16'sd1999, 1'b1);
        send_beat(CMD_SAMPLE, 16'd2000, 1'b1);
        send_beat(CMD_TICK, 16'h0000, 1'b0);
        // bit 15 of the write data falls outside the threshold field
        write_reg(REG_PEAK_THRESHOLD, 16'h8000);
        send_beat(CMD_SAMPLE, 16'd0, 1'b1);
        send_beat(CMD_TICK, 16'h0000, 1'b0);
        write_reg(REG_PEAK_THRESHOLD, 16'h7FFF);
        send_beat(CMD_SAMPLE, 16'd32766, 1'b1);
        send_beat(CMD_SAMPLE, 16'd32767, 1'b1);
        send_beat(CMD_TAKE, 16'h0000, 1'b0);
    endtask

    // longest holdoff, then a shorter one written while still held
    task automatic test_holdoff_limits();
        write_reg(REG_HOLDOFF_TICKS, 16'hFFFF);
        send_beat(CMD_TICK, 16'h0000, 1'b0);
        send_beat(CMD_TICK, 16'h0000, 1'b0);
        write_reg(REG_HOLDOFF_TICKS, 16'd1);
        send_beat(CMD_TICK, 16'h0000, 1'b0);
        send_beat(CMD_SAMPLE, -16'sd32767, 1'b1);
        send_beat(CMD_TICK, 16'h0000, 1'b0);
    endtask

    task automatic run_random_phase(input int n_live);
        int goal;
        int pick;
        int len;
        int i;
        goal = live_beats + n_live;
        while (live_beats < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                while (in_holdoff)
                    send_beat(CMD_TICK, 16'($urandom), 1'($urandom));
                len = $urandom_range(1, 8);
                for (i = 0; i < len; i++)
                    send_beat(CMD_SAMPLE, pick_sample(), i == len - 1);
            end else if (pick < 80) begin
                send_beat(CMD_TAKE, 16'($urandom), 1'($urandom));
            end else if (pick < 88) begin
                send_beat(CMD_TICK, 16'($urandom), 1'($urandom));
            end else if (pick < 92) begin
                send_beat(CMD_SPARE, 16'($urandom), 1'($urandom));
            end else begin
                send_beat(2'($urandom), 16'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        int p;
        logic [CFG_DATA_W-1:0] thr_data;
        logic [CFG_DATA_W-1:0] hold_data;
        for (p = 0; p < 6; p++) begin
            case (p)
                0: begin thr_data = 16'd2000; hold_data = 16'd0;
                         tx_idle_on = 1'b1; rx_idle_on = 1'b1; end
                1: begin thr_data = 16'd0; hold_data = 16'd1;
                         tx_idle_on = 1'b0; rx_idle_on = 1'b0; end
                2: begin thr_data = 16'h7FFF; hold_data = 16'd3;
                         tx_idle_on = 1'b1; rx_idle_on = 1'b0; end
                3: begin thr_data = 16'($urandom_range(0, 32767));
                         hold_data = 16'($urandom_range(0, 5));
                         tx_idle_on = 1'b0; rx_idle_on = 1'b1; end
                4: begin thr_data = 16'($urandom); hold_data = 16'd2;
                         tx_idle_on = 1'b1; rx_idle_on = 1'b1; end
                default: begin thr_data = 16'($urandom_range(16384, 32767));
                               hold_data = 16'd40; tx_idle_on = 1'b1;
                               rx_idle_on = 1'b1; end
            endcase
            write_reg(REG_PEAK_THRESHOLD, thr_data);
            write_reg(REG_HOLDOFF_TICKS, hold_data);
            run_random_phase(260);
        end
    endtask

    // long receiver hold while the sender keeps offering beats
    task automatic test_backpressure();
        write_reg(REG_PEAK_THRESHOLD, 16'd3000);
        write_reg(REG_HOLDOFF_TICKS, 16'd1);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        rx_hold_cycles = 200;
        run_random_phase(40);
        drain_results();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        run_random_phase(20);
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_holdoff();
        test_threshold_edges();
        test_holdoff_limits();
        test_random_traffic();
        test_backpressure();
        drain_results();
        repeat (5) @(posedge clk);
        $display("sent %0d beats (%0d acting on state), %0d register writes",
                 beats_sent, live_beats, reg_writes);
        $display("checked %0d results: %0d loud events, %0d flags taken, %0d mismatches",
                 results_checked, loud_events, flags_taken, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("burst_peak_loud_event_detector_test: PASS");
        end else begin
            $display("burst_peak_loud_event_detector_test: FAIL");
        end
        $finish;
    end

endmodule
